FILE: sv/bilinear_plasticity_return_map_core_defines.svh
// Assertion macros shared by the return-map core.
`ifndef BILINEAR_PLASTICITY_RETURN_MAP_CORE_DEFINES_SVH
`define BILINEAR_PLASTICITY_RETURN_MAP_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BPRM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BPRM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/bprm_pkg.sv
`default_nettype none

package bprm_pkg;

  localparam int MOD_W         = 32;   // moduli, yield stress, tangent
  localparam int INV_W         = 57;   // reciprocal of E+H, Q.56
  localparam int INV_FRAC_BITS = 56;
  localparam int STRAIN_W      = 32;
  localparam int STRESS_W      = 48;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 57;
  localparam int OUT_DATA_W    = STRESS_W + MOD_W + STRAIN_W + STRAIN_W;

  localparam logic signed [63:0] STRESS_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] STRESS_MIN = -64'sh0000_8000_0000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_YOUNG = 3'd0,
    CFG_YIELD = 3'd1,
    CFG_HARD  = 3'd2,
    CFG_INV   = 3'd3,
    CFG_PTAN  = 3'd4
  } cfg_idx_t;

  // operand pair for the shared multiplier
  typedef enum logic [2:0] {
    MSEL_TRIAL,   // |strain - plastic| * E
    MSEL_HARD,    // hardening_variable * H
    MSEL_INV_LO,  // excess * inv[31:0]
    MSEL_INV_HI,  // excess * inv[56:32]
    MSEL_CORR     // dg * E
  } mul_sel_t;

  typedef struct packed {
    logic     start;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     tmag_ld;
    logic     thr_ld;
    logic     cmp_ld;
    logic     acc_ld;
    logic     dg_ld;
    logic     upd_ld;
    logic     out_ld;
  } dp_cmd_t;

  typedef struct packed {
    logic over;   // trial magnitude above yield threshold
  } dp_sts_t;

endpackage

`default_nettype wire

FILE: sv/bilinear_plasticity_return_map_core.sv
// One strain is processed at a time: a new input is taken only once the controller is back
//   in idle, after the previous result has gone into the output register. The single shared
//   multiplier is stepped by the controller through its product chain.
// Reset (rst_n low, synchronous): controller idle, no pending result, plastic
//   strain and hardening cleared, configuration registers back to their defaults.
`default_nettype none

module bilinear_plasticity_return_map_core
  import bprm_pkg::*;
#(
  parameter int STRAIN_FRAC_BITS = 28   // strain fraction bits, 16 to 30
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // strain input stream
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [STRAIN_W-1:0]   in_tdata,    // [31:0] total_strain
  // result stream
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,   // [47:0] stress, [79:48] tangent,
                                                  // [111:80] plastic_strain_out,
                                                  // [143:112] hardening_out
  output logic                       out_tuser,   // [0] yielded
  // configuration write port
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // Controller walks the step sequence:
  //   accept -> E*|d| -> H*alpha -> threshold -> compare
  //   yielding: excess*inv (low, high) -> clamp dg -> E*dg + state update
  //   -> result load into the output register (waits if it is still occupied)
  // The output register frees the input side as soon as a result is loaded.

  dp_cmd_t cmd;
  dp_sts_t sts;

  bprm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // Datapath: config registers, plastic state, shared multiplier, result register.
  bprm_dp #(
    .STRAIN_FRAC_BITS (STRAIN_FRAC_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .total_strain (in_tdata),
    .cmd          (cmd),
    .sts          (sts),
    .out_data     (out_tdata),
    .out_yielded  (out_tuser)
  );

endmodule

`default_nettype wire

FILE: sv/bprm_ctrl.sv
`default_nettype none
`include "bilinear_plasticity_return_map_core_defines.svh"

module bprm_ctrl
  import bprm_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_tvalid,
  output logic         in_tready,
  output logic         out_tvalid,
  input  wire logic    out_tready,
  input  wire dp_sts_t sts,
  output dp_cmd_t      cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_T,
    ST_MUL_H,
    ST_THR,
    ST_CMP,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_DG,
    ST_MUL_C,
    ST_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign slot_free  = !out_valid_r || out_tready;

  always_comb begin
    cmd       = '0;
    cmd.mul_sel = MSEL_TRIAL;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.start = 1'b1;
          state_nxt = ST_MUL_T;
        end
      end
      ST_MUL_T: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MSEL_TRIAL;
        state_nxt   = ST_MUL_H;
      end
      ST_MUL_H: begin
        cmd.tmag_ld = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MSEL_HARD;
        state_nxt   = ST_THR;
      end
      ST_THR: begin
        cmd.thr_ld = 1'b1;
        state_nxt  = ST_CMP;
      end
      ST_CMP: begin
        cmd.cmp_ld = 1'b1;
        state_nxt  = sts.over ? ST_MUL_LO : ST_OUT;
      end
      ST_MUL_LO: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MSEL_INV_LO;
        state_nxt   = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd.acc_ld  = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MSEL_INV_HI;
        state_nxt   = ST_DG;
      end
      ST_DG: begin
        cmd.dg_ld = 1'b1;
        state_nxt = ST_MUL_C;
      end
      ST_MUL_C: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MSEL_CORR;
        cmd.upd_ld  = 1'b1;
        state_nxt   = ST_OUT;
      end
      ST_OUT: begin
        if (slot_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `BPRM_ASSERT_NEXT(a_busy_after_start, clk, rst_n, cmd.start, !in_tready, "input taken while busy")
  `BPRM_ASSERT_NEXT(a_load_shows, clk, rst_n, cmd.out_ld, out_tvalid, "loaded result not shown")
  `BPRM_ASSERT_NEXT(a_dg_then_update, clk, rst_n, cmd.dg_ld, cmd.upd_ld, "dg not applied to state")
  `BPRM_ASSERT_NEXT(a_over_starts_div, clk, rst_n, cmd.cmp_ld && sts.over, cmd.mul_en && (cmd.mul_sel == MSEL_INV_LO), "yield without correction")
  `BPRM_ASSERT_NEXT(a_elastic_no_update, clk, rst_n, cmd.cmp_ld && !sts.over, cmd.out_ld || !slot_free, "elastic step not finished")

endmodule

`default_nettype wire

FILE: sv/bprm_dp.sv
`default_nettype none

module bprm_dp
  import bprm_pkg::*;
#(
  parameter int STRAIN_FRAC_BITS = 28
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic [STRAIN_W-1:0]   total_strain,
  input  wire dp_cmd_t               cmd,
  output dp_sts_t                    sts,
  output logic [OUT_DATA_W-1:0]      out_data,
  output logic                       out_yielded
);

  localparam int S      = STRAIN_FRAC_BITS;
  localparam int MAG_W  = 2 * MOD_W + 1 - S;         // trial magnitude, threshold, excess
  localparam int PROD_W = MAG_W + MOD_W;
  localparam int SUM_W  = PROD_W + MOD_W + 1;
  localparam int DG_SH  = INV_FRAC_BITS - S;
  localparam int SV_W   = MAG_W + 2;

  // configuration
  logic [MOD_W-1:0] young_r, yield_r, hard_r, ptan_r;
  logic [INV_W-1:0] inv_r;

  // material state
  logic [STRAIN_W-1:0] plastic_r;
  logic [STRAIN_W-1:0] hv_r;

  // working registers
  logic [STRAIN_W:0]  dmag_r;
  logic               neg_r;
  logic [PROD_W-1:0]  prod_r, acc_r;
  logic [MAG_W-1:0]   tmag_r, thr_r, excess_r;
  logic [MOD_W-1:0]   dg_r;
  logic               yld_r;

  // result registers
  logic [STRESS_W-1:0] stress_r;
  logic [MOD_W-1:0]    tangent_r;
  logic [STRAIN_W-1:0] pl_out_r, hv_out_r;
  logic                yielded_r;

  logic signed [STRAIN_W:0] diff;
  logic [MAG_W-1:0]         mul_a;
  logic [MOD_W-1:0]         mul_b;
  logic [PROD_W-1:0]        prod;
  logic [MAG_W-1:0]         prod_sh;
  logic [SUM_W-1:0]         sum;
  logic [MOD_W-1:0]         dg_nxt;
  logic signed [STRAIN_W+1:0] p_sum;
  logic [STRAIN_W-1:0]      p_nxt;
  logic [STRAIN_W:0]        h_sum;
  logic [MAG_W-1:0]         corr;
  logic signed [MAG_W:0]    smag;
  logic signed [SV_W-1:0]   sval;
  logic signed [63:0]       s64;
  logic [STRESS_W-1:0]      stress_nxt;

  assign diff = $signed({total_strain[STRAIN_W-1], total_strain})
              - $signed({plastic_r[STRAIN_W-1], plastic_r});

  always_comb begin
    unique case (cmd.mul_sel)
      MSEL_TRIAL: begin
        mul_a = MAG_W'(dmag_r);
        mul_b = young_r;
      end
      MSEL_HARD: begin
        mul_a = MAG_W'(hv_r);
        mul_b = hard_r;
      end
      MSEL_INV_LO: begin
        mul_a = excess_r;
        mul_b = inv_r[MOD_W-1:0];
      end
      MSEL_INV_HI: begin
        mul_a = excess_r;
        mul_b = MOD_W'(inv_r[INV_W-1:MOD_W]);
      end
      MSEL_CORR: begin
        mul_a = MAG_W'(dg_r);
        mul_b = young_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod    = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign prod_sh = prod_r[S +: MAG_W];

  assign sts.over = tmag_r > thr_r;

  // excess * inv over two partial products, then >> (56 - S) with clamp
  assign sum    = SUM_W'({prod_r, {MOD_W{1'b0}}}) + SUM_W'(acc_r);
  assign dg_nxt = (|sum[SUM_W-1:DG_SH+MOD_W]) ? '1 : sum[DG_SH +: MOD_W];

  // state update with saturation
  always_comb begin
    if (neg_r) begin
      p_sum = $signed({{2{plastic_r[STRAIN_W-1]}}, plastic_r}) - $signed({2'b00, dg_r});
    end else begin
      p_sum = $signed({{2{plastic_r[STRAIN_W-1]}}, plastic_r}) + $signed({2'b00, dg_r});
    end
    if (p_sum[STRAIN_W+1:STRAIN_W-1] == 3'b000 || p_sum[STRAIN_W+1:STRAIN_W-1] == 3'b111) begin
      p_nxt = p_sum[STRAIN_W-1:0];
    end else if (p_sum[STRAIN_W+1]) begin
      p_nxt = {1'b1, {(STRAIN_W-1){1'b0}}};
    end else begin
      p_nxt = {1'b0, {(STRAIN_W-1){1'b1}}};
    end
  end

  assign h_sum = {1'b0, hv_r} + {1'b0, dg_r};

  // corrected stress, sign restore, 48-bit saturation
  assign corr = yld_r ? prod_sh : '0;
  assign smag = $signed({1'b0, tmag_r}) - $signed({1'b0, corr});
  assign sval = neg_r ? -SV_W'(smag) : SV_W'(smag);
  assign s64  = 64'(sval);

  always_comb begin
    if (s64 > STRESS_MAX) begin
      stress_nxt = STRESS_MAX[STRESS_W-1:0];
    end else if (s64 < STRESS_MIN) begin
      stress_nxt = STRESS_MIN[STRESS_W-1:0];
    end else begin
      stress_nxt = s64[STRESS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      young_r   <= MOD_W'(256);
      yield_r   <= MOD_W'(256);
      hard_r    <= '0;
      inv_r     <= INV_W'(64'd281474976710656);
      ptan_r    <= '0;
      plastic_r <= '0;
      hv_r      <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_YOUNG: young_r <= cfg_data[MOD_W-1:0];
          CFG_YIELD: yield_r <= cfg_data[MOD_W-1:0];
          CFG_HARD:  hard_r  <= cfg_data[MOD_W-1:0];
          CFG_INV:   inv_r   <= cfg_data[INV_W-1:0];
          CFG_PTAN:  ptan_r  <= cfg_data[MOD_W-1:0];
          default: ;
        endcase
      end
      if (cmd.upd_ld) begin
        plastic_r <= p_nxt;
        hv_r      <= h_sum[STRAIN_W] ? '1 : h_sum[STRAIN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      neg_r  <= diff[STRAIN_W];
      dmag_r <= diff[STRAIN_W] ? 33'(-diff) : 33'(diff);
    end
    if (cmd.mul_en) begin
      prod_r <= prod;
    end
    if (cmd.tmag_ld) begin
      tmag_r <= prod_sh;
    end
    if (cmd.thr_ld) begin
      thr_r <= MAG_W'(yield_r) + prod_sh;
    end
    if (cmd.cmp_ld) begin
      excess_r <= tmag_r - thr_r;
      yld_r    <= sts.over;
    end
    if (cmd.acc_ld) begin
      acc_r <= prod_r;
    end
    if (cmd.dg_ld) begin
      dg_r <= dg_nxt;
    end
    if (cmd.out_ld) begin
      stress_r  <= stress_nxt;
      tangent_r <= yld_r ? ptan_r : young_r;
      pl_out_r  <= plastic_r;
      hv_out_r  <= hv_r;
      yielded_r <= yld_r;
    end
  end

  assign out_data    = {hv_out_r, pl_out_r, tangent_r, stress_r};
  assign out_yielded = yielded_r;

endmodule

`default_nettype wire

FILE: tb/sv/bilinear_plasticity_return_map_core_tb.sv
`timescale 1ns / 1ps

module bilinear_plasticity_return_map_core_tb;
  import bprm_pkg::*;

  // ---------------------------------------------------------------------------
  // Run constants
  // ---------------------------------------------------------------------------
  localparam int     FRAC        = 28;       // strain fraction bits of the instance
  localparam int     N_PHASES    = 6;        // random material phases
  localparam int     PER_PHASE   = 313;      // strain samples per phase
  localparam int     SETTLE      = 16;       // extra wait used when draining
  localparam int     LONG_HOLD   = 400;      // receiver back-pressure stretch
  localparam longint CYCLE_LIMIT = 600000;

  // index 7 is not mapped; writes to it must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  // one result transfer, fields in port order
  typedef struct packed {
    logic [STRESS_W-1:0] stress;
    logic [MOD_W-1:0]    tangent;
    logic [STRAIN_W-1:0] plastic;
    logic [STRAIN_W-1:0] hardening;
    logic                yielded;
  } point_result_t;

  typedef enum logic [1:0] {
    ROW_STRAIN,    // strain sample, checked against the predictor
    ROW_CHECKED,   // strain sample with the result typed in below
    ROW_REG        // register write
  } row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] value;   // strain in [31:0] for sample rows
    point_result_t         want;
  } stim_row_t;

  localparam point_result_t NO_CHECK = '0;
  localparam int N_DIR = 30;

  // Directed table. Starts on the reset material: E = 1.0, yield = 1.0, H = 0,
  // reciprocal 2^48, plastic tangent 0.
  localparam stim_row_t DIRECTED [N_DIR] = '{
    // zero strain, fully elastic
    '{ROW_CHECKED, CFG_SPARE, 57'h0000_0000, '{48'd0,   32'd256, 32'h0, 32'h0, 1'b0}},
    // trial exactly at yield: not yielding (strict compare)
    '{ROW_CHECKED, CFG_SPARE, 57'h1000_0000, '{48'd256, 32'd256, 32'h0, 32'h0, 1'b0}},
    // one LSB over yield: dg = 2^20, stress pulled back to yield
    '{ROW_CHECKED, CFG_SPARE, 57'h1010_0000,
      '{48'd256, 32'd0, 32'h0010_0000, 32'h0010_0000, 1'b1}},
    // strain equal to plastic strain: zero difference counts positive
    '{ROW_CHECKED, CFG_SPARE, 57'h0010_0000,
      '{48'd0, 32'd256, 32'h0010_0000, 32'h0010_0000, 1'b0}},
    '{ROW_STRAIN,  CFG_SPARE, 57'h8000_0000, NO_CHECK},
    '{ROW_STRAIN,  CFG_SPARE, 57'h7FFF_FFFF, NO_CHECK},
    '{ROW_STRAIN,  CFG_SPARE, 57'hFFFF_FFFF, NO_CHECK},
    // unmapped register index
    '{ROW_REG,     CFG_SPARE, 57'h1FF_FFFF_FFFF_FFFF, NO_CHECK},
    '{ROW_STRAIN,  CFG_SPARE, 57'h0000_0001, NO_CHECK},
    // extreme material: dg clamp, plastic and hardening saturation, sign flip
    '{ROW_REG,     CFG_YOUNG, 57'hFFFF_FFFF, NO_CHECK},
    '{ROW_REG,     CFG_YIELD, 57'h0000_0001, NO_CHECK},
    '{ROW_REG,     CFG_HARD,  57'hFFFF_FFFF, NO_CHECK},
    '{ROW_REG,     CFG_INV,   57'h100_0000_0000_0000, NO_CHECK},
    '{ROW_REG,     CFG_PTAN,  57'hFFFF_FFFF, NO_CHECK},
    '{ROW_STRAIN,  CFG_SPARE, 57'h7FFF_FFFF, NO_CHECK},
    '{ROW_STRAIN,  CFG_SPARE, 57'h8000_0000, NO_CHECK},
    '{ROW_STRAIN,  CFG_SPARE, 57'h7FFF_FFFF, NO_CHECK},
    '{ROW_STRAIN,  CFG_SPARE, 57'h0000_0000, NO_CHECK},
    '{ROW_STRAIN,  CFG_SPARE, 57'h8000_0000, NO_CHECK},
    '{ROW_STRAIN,  CFG_SPARE, 57'h1234_5678, NO_CHECK},
    // zero modulus: trial stress is always zero
    '{ROW_REG,     CFG_YOUNG, 57'h0000_0000, NO_CHECK},
    '{ROW_STRAIN,  CFG_SPARE, 57'h4000_0000, NO_CHECK},
    // smallest material, zero reciprocal: yields with dg = 0
    '{ROW_REG,     CFG_YOUNG, 57'h0000_0001, NO_CHECK},
    '{ROW_REG,     CFG_YIELD, 57'h0000_0001, NO_CHECK},
    '{ROW_REG,     CFG_HARD,  57'h0000_0000, NO_CHECK},
    '{ROW_REG,     CFG_INV,   57'h0000_0000, NO_CHECK},
    '{ROW_REG,     CFG_PTAN,  57'h0000_0001, NO_CHECK},
    '{ROW_STRAIN,  CFG_SPARE, 57'h7FFF_FFFF, NO_CHECK},
    '{ROW_STRAIN,  CFG_SPARE, 57'h8000_0000, NO_CHECK},
    '{ROW_STRAIN,  CFG_SPARE, 57'h0000_0001, NO_CHECK}
  };

  // ---------------------------------------------------------------------------
  // DUT hookup; every input known from time zero
  // ---------------------------------------------------------------------------
  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [STRAIN_W-1:0]   in_tdata  = '0;      // [31:0] total_strain
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;           // [47:0] stress, [79:48] tangent,
                                              // [111:80] plastic_strain_out,
                                              // [143:112] hardening_out
  logic                  out_tuser;           // [0] yielded
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  bilinear_plasticity_return_map_core #(
    .STRAIN_FRAC_BITS (FRAC)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Material shadow and point state, mirrored at every accepted transfer
  // ---------------------------------------------------------------------------
  logic [MOD_W-1:0]      mat_young   = 32'd256;
  logic [MOD_W-1:0]      mat_yield   = 32'd256;
  logic [MOD_W-1:0]      mat_hard    = 32'd0;
  logic [CFG_DATA_W-1:0] mat_inv     = 57'h1_0000_0000_0000;   // 2^48
  logic [MOD_W-1:0]      mat_ptan    = 32'd0;
  logic [STRAIN_W-1:0]   plastic_q   = '0;   // signed Q4.28
  logic [STRAIN_W-1:0]   hard_q      = '0;   // unsigned Q4.28

  point_result_t pending_points [$];   // expected results, oldest first

  int     n_errors      = 0;
  int     n_results     = 0;
  int     send_idle_pct = 21;
  int     recv_idle_pct = 67;
  logic   hold_req      = 1'b0;   // toggled to ask for one long receiver hold-off
  logic   hold_ack      = 1'b0;
  int     hold_left     = 0;
  longint cycle_count   = 0;

  // Radial return on one strain sample. Advances plastic_q / hard_q.
  function automatic point_result_t return_map_step(input logic [STRAIN_W-1:0] strain);
    logic signed [63:0] diff, moved, smag, sval;
    logic               neg;
    logic [63:0]        dmag, tmag, thr, hsum, corr;
    logic [127:0]       scaled;
    logic [31:0]        dg;
    point_result_t      r;
    diff = {{32{strain[31]}}, strain} - {{32{plastic_q[31]}}, plastic_q};
    neg  = diff[63];
    dmag = neg ? -diff : diff;
    tmag = (dmag * {32'd0, mat_young}) >> FRAC;
    thr  = {32'd0, mat_yield} + (({32'd0, mat_hard} * {32'd0, hard_q}) >> FRAC);
    smag = tmag;
    r.tangent = mat_young;
    r.yielded = 1'b0;
    if (tmag > thr) begin
      // dg = excess * reciprocal, back to Q.28, clamped to 32 bits
      scaled = ({64'd0, tmag - thr} * {71'd0, mat_inv}) >> (INV_FRAC_BITS - FRAC);
      dg     = (|scaled[127:32]) ? 32'hFFFF_FFFF : scaled[31:0];
      moved  = neg ? {{32{plastic_q[31]}}, plastic_q} - {32'd0, dg}
                   : {{32{plastic_q[31]}}, plastic_q} + {32'd0, dg};
      if (moved > 64'sh7FFF_FFFF)       plastic_q = 32'h7FFF_FFFF;
      else if (moved < -64'sh8000_0000) plastic_q = 32'h8000_0000;
      else                              plastic_q = moved[31:0];
      hsum   = {32'd0, hard_q} + {32'd0, dg};
      hard_q = hsum[32] ? 32'hFFFF_FFFF : hsum[31:0];
      corr   = ({32'd0, mat_young} * {32'd0, dg}) >> FRAC;
      smag   = tmag - corr;   // may go negative and flip the sign
      r.tangent = mat_ptan;
      r.yielded = 1'b1;
    end
    sval = neg ? -smag : smag;
    if (sval > STRESS_MAX)      sval = STRESS_MAX;
    else if (sval < STRESS_MIN) sval = STRESS_MIN;
    r.stress    = sval[STRESS_W-1:0];
    r.plastic   = plastic_q;
    r.hardening = hard_q;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver tasks; each is entered right after a rising edge
  // ---------------------------------------------------------------------------

  // Offer one strain; the expectation is queued on the accepting edge.
  task automatic send_strain(input logic [STRAIN_W-1:0] strain, input logic typed,
                             input point_result_t typed_want);
    point_result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= strain;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = return_map_step(strain);   // state advances either way
    pending_points.push_back(typed ? typed_want : r);
  endtask

  // Stop offering, let every result come back, then let the core settle.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_YOUNG: mat_young = val[MOD_W-1:0];
      CFG_YIELD: mat_yield = val[MOD_W-1:0];
      CFG_HARD:  mat_hard  = val[MOD_W-1:0];
      CFG_INV:   mat_inv   = val;
      CFG_PTAN:  mat_ptan  = val[MOD_W-1:0];
      default: ;   // unmapped index: nothing changes
    endcase
    @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("ERROR result %0d %s: got 0x%0h, expected 0x%0h", n_results, what, got, want);
    n_errors++;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random ready, plus one long hold-off on request so the core
  // backs up and stalls its input
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left  <= 0;
      hold_ack   <= 1'b0;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      out_tready <= 1'b0;
      hold_left  <= LONG_HOLD;
      hold_ack   <= hold_req;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every transfer against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    point_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_points.size() == 0) begin
        report_mismatch("unexpected transfer", out_tdata[63:0], 64'd0);
      end else begin
        want = pending_points.pop_front();
        if (out_tdata[0 +: STRESS_W] !== want.stress)
          report_mismatch("stress", 64'(out_tdata[0 +: STRESS_W]), 64'(want.stress));
        if (out_tdata[STRESS_W +: MOD_W] !== want.tangent)
          report_mismatch("tangent", 64'(out_tdata[STRESS_W +: MOD_W]), 64'(want.tangent));
        if (out_tdata[STRESS_W+MOD_W +: STRAIN_W] !== want.plastic)
          report_mismatch("plastic_strain_out",
                          64'(out_tdata[STRESS_W+MOD_W +: STRAIN_W]), 64'(want.plastic));
        if (out_tdata[STRESS_W+MOD_W+STRAIN_W +: STRAIN_W] !== want.hardening)
          report_mismatch("hardening_out",
                          64'(out_tdata[STRESS_W+MOD_W+STRAIN_W +: STRAIN_W]),
                          64'(want.hardening));
        if (out_tuser !== want.yielded)
          report_mismatch("yielded", 64'(out_tuser), 64'(want.yielded));
      end
      n_results++;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed table, then random strain paths per material
  // ---------------------------------------------------------------------------
  initial begin : run_seq
    logic [MOD_W-1:0]      e_mod, y_str, h_mod, pt;
    logic [CFG_DATA_W-1:0] inv;
    logic [63:0]           sum, eps_y;
    int unsigned           span;
    longint                pos, dir;
    int                    pick;
    logic [STRAIN_W-1:0]   s;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIR; i++) begin
      if (DIRECTED[i].kind == ROW_REG) begin
        wait_drained();
        write_reg(DIRECTED[i].index, DIRECTED[i].value);
      end else begin
        send_strain(DIRECTED[i].value[STRAIN_W-1:0], DIRECTED[i].kind == ROW_CHECKED,
                    DIRECTED[i].want);
      end
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      wait_drained();

      // idling: slow receiver, then slow sender, then full rate
      case (ph / 2)
        0:       begin send_idle_pct <= 21; recv_idle_pct <= 67; end
        1:       begin send_idle_pct <= 67; recv_idle_pct <= 21; end
        default: begin send_idle_pct <= 0;  recv_idle_pct <= 0;  end
      endcase

      // material: consistent sets, except phase 2 which loads raw random words
      e_mod = $urandom_range(64, 1 << 20);
      eps_y = 64'($urandom_range(1 << 22, 1 << 28));   // yield strain, Q4.28
      case (ph)
        1:       h_mod = 0;                               // perfect plasticity
        3:       h_mod = $urandom_range(0, 4 * e_mod);    // hardening up to four times E
        4:       begin
                   e_mod = $urandom_range(1, 255);       // soft material
                   h_mod = $urandom_range(0, e_mod);
                 end
        default: h_mod = $urandom_range(0, e_mod);
      endcase
      y_str = 32'(({32'd0, e_mod} * eps_y) >> FRAC);
      if (y_str == 0) y_str = 1;
      sum = {32'd0, e_mod} + {32'd0, h_mod};
      inv = 57'((64'h0100_0000_0000_0000) / sum);
      pt  = 32'(({32'd0, e_mod} * {32'd0, h_mod}) / sum);
      span = 32'(eps_y);
      if (ph == 2) begin
        e_mod = $urandom;
        y_str = $urandom;
        h_mod = $urandom;
        inv   = {$urandom_range(1) == 0 ? 25'd0 : 25'h100_0000, 32'($urandom)};
        inv   = inv | {1'b0, 24'($urandom), 32'd0};
        pt    = $urandom;
        span  = $urandom_range(1 << 20, 1 << 29);
      end
      write_reg(CFG_YOUNG, CFG_DATA_W'(e_mod));
      write_reg(CFG_YIELD, CFG_DATA_W'(y_str));
      write_reg(CFG_HARD,  CFG_DATA_W'(h_mod));
      write_reg(CFG_INV,   inv);
      write_reg(CFG_PTAN,  CFG_DATA_W'(pt));

      // long receiver stall while the sender keeps offering
      if (ph == 3 || ph == 5) hold_req <= ~hold_req;

      // Mostly load/unload cycles around the yield strain; the rest is noise
      // and broken paths that jump anywhere.
      pos = 0;
      dir = 1;
      repeat (PER_PHASE) begin
        pick = $urandom_range(99);
        if (pick < 12) begin
          s = $urandom;
        end else if (pick < 17) begin
          pos = longint'($signed($urandom));
          s   = pos[31:0];
        end else begin
          if (pos > 3 * longint'(span))       dir = -1;
          else if (pos < -3 * longint'(span)) dir = 1;
          else if ($urandom_range(9) == 0)    dir = -dir;
          pos = pos + dir * longint'($urandom_range(span / 2));
          if (pos > 64'sh7FFF_FFFF)       pos = 64'sh7FFF_FFFF;
          else if (pos < -64'sh8000_0000) pos = -64'sh8000_0000;
          s = pos[31:0];
        end
        send_strain(s, 1'b0, NO_CHECK);
      end
    end

    wait_drained();
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
